>>> rtl/time_value_scale_saturating_defines.svh
// Assertion macros shared by the time value scaler checks.
`ifndef TIME_VALUE_SCALE_SATURATING_DEFINES_SVH
`define TIME_VALUE_SCALE_SATURATING_DEFINES_SVH

// Check a condition in the same cycle as its trigger, outside reset.
`define TVSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvss check failed: same-cycle condition");

// Check a condition in the cycle after its trigger, outside reset.
`define TVSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvss check failed: next-cycle condition");

// Check a condition in the cycle after its trigger, reset included.
`define TVSS_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tvss check failed: reset condition");

`endif

>>> rtl/tvss_pkg.sv
// Shared constants and types for the saturating time value scaler.
`timescale 1ns / 1ps
`default_nettype none

package tvss_pkg;

  // Stream payload layout
  localparam int SEC_W      = 64;
  localparam int NS_W       = 30;
  localparam int FAC_W      = 32;
  localparam int S_TDATA_W  = 128;
  localparam int M_TDATA_W  = 96;
  localparam int M_TUSER_W  = 1;

  // Nanosecond constants
  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [NS_W-1:0] NS_MAX     = 30'd999999999;

  // Multiples of one second for the radix-4 divide steps
  localparam int DIV_W = NS_W + 2;
  localparam logic [DIV_W-1:0] DIV_X1 = 32'd1000000000;
  localparam logic [DIV_W-1:0] DIV_X2 = 32'd2000000000;
  localparam logic [DIV_W-1:0] DIV_X3 = 32'd3000000000;

  // How the output stage forms the result of one request
  typedef enum logic [1:0] {
    MODE_CALC = 2'b00,
    MODE_ZERO = 2'b01,
    MODE_PASS = 2'b10,
    MODE_SAT  = 2'b11
  } mode_t;

endpackage

`default_nettype wire

>>> rtl/time_value_scale_saturating.sv
// Saturating multiply of a seconds/nanoseconds time value by a signed factor.
//
// Usage:
//   Input stream s_axis carries one request per beat: seconds (signed), nanoseconds
//   (0..999999999) and a signed scale factor. Output stream m_axis returns the floor
//   product as seconds plus nanoseconds in range, and a saturation flag in tuser.
//   Results pass through registered prep, multiply, divide, add and output stages.
//   Throughput is one request per cycle while m_axis does not stall; the depth
//   comes from the radix-4 divide-by-one-billion chain, two quotient bits per stage,
//   that splits the nanosecond product into carried seconds and a remainder.
//   Every stage carries a valid bit. A stage holds its contents only while the stage
//   after it is full and stalled, so bubbles collapse and s_axis_tready drops only
//   once all stages are full behind a stalled m_axis. Nothing is dropped or repeated.
//   Reset (rst, synchronous) clears all valid bits and holds s_axis_tready low; no
//   request survives it and the block accepts the next request in the cycle after
//   reset is released.
//   A factor of zero gives zero; a factor of one passes the value through unchanged.
//   Overflow saturates to the most negative seconds with 0 ns, or to the largest
//   seconds with 999999999 ns, and raises the flag.
`timescale 1ns / 1ps
`default_nettype none

module time_value_scale_saturating #(
  parameter int SECONDS_WIDTH = 64,
  parameter int FACTOR_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [63:0] seconds_in, [93:64] nanos_in, [125:94] scale_factor, [127:126] zero
  input  logic [tvss_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [63:0] seconds_out, [93:64] nanos_out, [95:94] zero
  output logic [tvss_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] range_error
  output logic [tvss_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  import tvss_pkg::*;

  localparam int SW     = SECONDS_WIDTH;
  localparam int FW     = FACTOR_WIDTH;
  localparam int MAG_W  = SW - 1;            // magnitude of a non-minimum seconds value
  localparam int LO_W   = MAG_W / 2;         // low slice of the magnitude multiply
  localparam int HI_W   = MAG_W - LO_W;      // high slice of the magnitude multiply
  localparam int PL_W   = LO_W + FW;
  localparam int PH_W   = HI_W + FW;
  localparam int PROD_W = MAG_W + FW;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QSTEPS = (FW + 1) / 2;      // radix-4 divide stages
  localparam int QW     = 2 * QSTEPS;        // quotient width
  localparam int XW     = NS_W + QW;         // nanosecond product width
  localparam int LAST   = QSTEPS - 1;

  // Control and pass-through fields that ride along every stage
  typedef struct packed {
    mode_t           mode;
    logic            neg;
    logic [SW-1:0]   sraw;
    logic [NS_W-1:0] nsraw;
  } carry_t;

  // One radix-4 restoring step: shift two dividend bits into the remainder,
  // subtract the largest fitting multiple of one second, shift the digit in.
  function automatic logic [NS_W+QW-1:0] div_step(input logic [NS_W-1:0] rem,
                                                  input logic [QW-1:0]   qx);
    logic [DIV_W-1:0] t;
    logic [DIV_W-1:0] r;
    logic [1:0]       q;
    t = {rem, qx[QW-1:QW-2]};
    if (t >= DIV_X3) begin
      q = 2'd3;
      r = t - DIV_X3;
    end else if (t >= DIV_X2) begin
      q = 2'd2;
      r = t - DIV_X2;
    end else if (t >= DIV_X1) begin
      q = 2'd1;
      r = t - DIV_X1;
    end else begin
      q = 2'd0;
      r = t;
    end
    return {r[NS_W-1:0], qx[QW-3:0], q};
  endfunction

  // ---------------------------------------------------------------------------
  // Stage ready chain: a stage takes new contents when empty or when its
  // successor takes its current contents.
  // ---------------------------------------------------------------------------
  logic prep_valid, mul_valid, add_valid, out_valid;
  logic prep_ready, mul_ready, add_ready, out_ready;
  logic div_valid [QSTEPS];
  logic div_ready [QSTEPS];

  assign out_ready     = !out_valid || m_axis_tready;
  assign add_ready     = !add_valid || out_ready;
  assign mul_ready     = !mul_valid || div_ready[0];
  assign prep_ready    = !prep_valid || mul_ready;
  // hold off the sender while reset flushes the pipeline
  assign s_axis_tready = prep_ready && !rst;

  // ---------------------------------------------------------------------------
  // Prep stage: decode special factors, form magnitudes.
  // ---------------------------------------------------------------------------
  logic [SEC_W-1:0] sec_in;
  logic [NS_W-1:0]  ns_in;
  logic [FAC_W-1:0] fac_in;
  logic [SW-1:0]    sraw_in;
  logic [FW-1:0]    fraw_in;
  logic             s_neg_in;
  logic             f_neg_in;
  logic [NS_W-1:0]  ns_clamp;
  carry_t           prep_ctl_next;
  logic [MAG_W-1:0] smag_next;
  logic [FW-1:0]    fmag_next;
  logic [NS_W-1:0]  nsm_next;

  assign sec_in   = s_axis_tdata[SEC_W-1:0];
  assign ns_in    = s_axis_tdata[SEC_W +: NS_W];
  assign fac_in   = s_axis_tdata[SEC_W+NS_W +: FAC_W];
  assign sraw_in  = sec_in[SW-1:0];
  assign fraw_in  = fac_in[FW-1:0];
  assign s_neg_in = sraw_in[SW-1];
  assign f_neg_in = fraw_in[FW-1];
  assign ns_clamp = (ns_in > NS_MAX) ? NS_MAX : ns_in;

  always_comb begin
    prep_ctl_next.neg   = s_neg_in ^ f_neg_in;
    prep_ctl_next.sraw  = sraw_in;
    prep_ctl_next.nsraw = ns_in;
    if (fraw_in == '0) begin
      prep_ctl_next.mode = MODE_ZERO;
    end else if (fraw_in == FW'(1)) begin
      prep_ctl_next.mode = MODE_PASS;
    end else if (sraw_in == {1'b1, {MAG_W{1'b0}}}) begin
      // most negative seconds has no magnitude: saturate
      prep_ctl_next.mode = MODE_SAT;
    end else begin
      prep_ctl_next.mode = MODE_CALC;
    end
    fmag_next = f_neg_in ? (~fraw_in + FW'(1)) : fraw_in;
    // a negative value with nonzero nanoseconds borrows one second:
    // magnitude = (-s - 1) s + (1e9 - ns) ns, and -s - 1 is ~s
    if (s_neg_in) begin
      smag_next = ~sraw_in[MAG_W-1:0] + MAG_W'(ns_clamp == '0);
      nsm_next  = (ns_clamp != '0) ? (NS_PER_SEC - ns_clamp) : ns_clamp;
    end else begin
      smag_next = sraw_in[MAG_W-1:0];
      nsm_next  = ns_clamp;
    end
  end

  carry_t           prep_ctl;
  logic [MAG_W-1:0] prep_smag;
  logic [FW-1:0]    prep_fmag;
  logic [NS_W-1:0]  prep_nsm;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (prep_ready) begin
      prep_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_ready) begin
      prep_ctl  <= prep_ctl_next;
      prep_smag <= smag_next;
      prep_fmag <= fmag_next;
      prep_nsm  <= nsm_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: seconds magnitude in two slices, nanoseconds in one.
  // ---------------------------------------------------------------------------
  carry_t          mul_ctl;
  logic [PL_W-1:0] mul_pl;
  logic [PH_W-1:0] mul_ph;
  logic [XW-1:0]   mul_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= prep_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready) begin
      mul_ctl <= prep_ctl;
      mul_pl  <= PL_W'(prep_smag[LO_W-1:0]) * PL_W'(prep_fmag);
      mul_ph  <= PH_W'(prep_smag[MAG_W-1:LO_W]) * PH_W'(prep_fmag);
      mul_x   <= XW'(prep_nsm) * XW'(prep_fmag);
    end
  end

  // ---------------------------------------------------------------------------
  // Divide chain: nanosecond product / 1e9, two quotient bits per stage.
  // The product is below 1e9 * 2^(QW-1), so its top NS_W bits start as a
  // valid remainder. The first stage also joins the two seconds slices.
  // ---------------------------------------------------------------------------
  carry_t            div_ctl  [QSTEPS];
  logic [NS_W-1:0]   div_rem  [QSTEPS];
  logic [QW-1:0]     div_qx   [QSTEPS];
  logic [PROD_W-1:0] div_prod [QSTEPS];

  for (genvar k = 0; k < QSTEPS; k++) begin : g_div
    logic              up_valid;
    carry_t            up_ctl;
    logic [NS_W-1:0]   up_rem;
    logic [QW-1:0]     up_qx;
    logic [PROD_W-1:0] up_prod;
    logic              down_ready;
    logic [NS_W+QW-1:0] step;

    if (k == 0) begin : g_first
      assign up_valid = mul_valid;
      assign up_ctl   = mul_ctl;
      assign up_rem   = mul_x[XW-1:QW];
      assign up_qx    = mul_x[QW-1:0];
      assign up_prod  = (PROD_W'(mul_ph) << LO_W) + PROD_W'(mul_pl);
    end else begin : g_rest
      assign up_valid = div_valid[k-1];
      assign up_ctl   = div_ctl[k-1];
      assign up_rem   = div_rem[k-1];
      assign up_qx    = div_qx[k-1];
      assign up_prod  = div_prod[k-1];
    end

    if (k == LAST) begin : g_tail
      assign down_ready = add_ready;
    end else begin : g_mid
      assign down_ready = div_ready[k+1];
    end

    assign div_ready[k] = !div_valid[k] || down_ready;
    assign step         = div_step(up_rem, up_qx);

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[k] <= 1'b0;
      end else if (div_ready[k]) begin
        div_valid[k] <= up_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (div_ready[k]) begin
        div_ctl[k]  <= up_ctl;
        div_rem[k]  <= step[NS_W+QW-1:QW];
        div_qx[k]   <= step[QW-1:0];
        div_prod[k] <= up_prod;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Add stage: carry the whole seconds into the magnitude product. Anything
  // above the magnitude width means the result exceeds the largest seconds.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] total;
  carry_t           add_ctl;
  logic [MAG_W-1:0] add_mag;
  logic             add_ovf;
  logic [NS_W-1:0]  add_rem;

  assign total = SUM_W'(div_prod[LAST]) + SUM_W'(div_qx[LAST]);

  always_ff @(posedge clk) begin
    if (rst) begin
      add_valid <= 1'b0;
    end else if (add_ready) begin
      add_valid <= div_valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (add_ready) begin
      add_ctl <= div_ctl[LAST];
      add_mag <= total[MAG_W-1:0];
      add_ovf <= |total[SUM_W-1:MAG_W];
      add_rem <= div_rem[LAST];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: restore the sign, borrow from the seconds for a nonzero
  // remainder, select pass-through or saturation. Registered output.
  // ---------------------------------------------------------------------------
  logic [SW-1:0]   res_sec;
  logic [NS_W-1:0] res_ns;
  logic            res_err;
  logic            sat;

  always_comb begin
    res_sec = '0;
    res_ns  = '0;
    res_err = 1'b0;
    sat     = 1'b0;
    unique case (add_ctl.mode)
      MODE_ZERO: begin
        res_sec = '0;
        res_ns  = '0;
      end
      MODE_PASS: begin
        res_sec = add_ctl.sraw;
        res_ns  = add_ctl.nsraw;
      end
      MODE_SAT: begin
        sat = 1'b1;
      end
      MODE_CALC: begin
        if (add_ovf) begin
          sat = 1'b1;
        end else if (add_ctl.neg) begin
          if (add_rem != '0) begin
            // floor of a negative value: -m - 1 seconds, 1e9 - r nanoseconds
            res_sec = ~{1'b0, add_mag};
            res_ns  = NS_PER_SEC - add_rem;
          end else begin
            res_sec = ~{1'b0, add_mag} + SW'(1);
            res_ns  = '0;
          end
        end else begin
          res_sec = {1'b0, add_mag};
          res_ns  = add_rem;
        end
      end
    endcase
    if (sat) begin
      res_err = 1'b1;
      if (add_ctl.neg) begin
        res_sec = {1'b1, {MAG_W{1'b0}}};
        res_ns  = '0;
      end else begin
        res_sec = {1'b0, {MAG_W{1'b1}}};
        res_ns  = NS_MAX;
      end
    end
  end

  logic [SEC_W-1:0] out_sec;
  logic [NS_W-1:0]  out_ns;
  logic             out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= add_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_sec <= SEC_W'($signed(res_sec));
      out_ns  <= res_ns;
      out_err <= res_err;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(M_TDATA_W-SEC_W-NS_W)'(0), out_ns, out_sec};
  assign m_axis_tuser  = out_err;

endmodule

`default_nettype wire

>>> rtl/tvss_checker.sv
// Port-level checks for the saturating time value scaler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "time_value_scale_saturating_defines.svh"

module tvss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [tvss_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tvss_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [tvss_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  import tvss_pkg::*;

  logic       in_take;
  logic       out_take;
  logic [7:0] inflight;
  logic [7:0] inflight_next;
  logic [NS_W-1:0] ns_seen;

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign ns_seen  = m_axis_tdata[SEC_W +: NS_W];

  // Track requests accepted but not yet delivered
  always_comb begin
    inflight_next = inflight;
    if (in_take && !out_take) begin
      inflight_next = inflight + 8'd1;
    end else if (!in_take && out_take) begin
      inflight_next = inflight - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `TVSS_ASSERT_NEXT(hold_on_stall, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `TVSS_ASSERT_RST(flush_on_reset, clk, rst, !m_axis_tvalid)
  `TVSS_ASSERT_NOW(no_orphan_result, clk, rst, m_axis_tvalid, inflight != '0)
  `TVSS_ASSERT_NOW(saturated_shape, clk, rst, m_axis_tvalid && m_axis_tuser[0], (ns_seen == '0 && m_axis_tdata[SEC_W-1]) || (ns_seen == NS_MAX && !m_axis_tdata[SEC_W-1]))

endmodule

bind time_value_scale_saturating tvss_checker u_tvss_checker (.*);

`default_nettype wire

>>> tb/sv/tb_time_value_scale_saturating.sv
// Self-checking testbench for the saturating time value scaler.
`timescale 1ns / 1ps

module tb_time_value_scale_saturating;

  import tvss_pkg::*;

  // Full-width views of the seconds and factor extremes
  localparam logic [63:0] SEC_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SEC_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] FAC_MIN      = 32'h8000_0000;
  localparam logic [31:0] FAC_MAX      = 32'h7FFF_FFFF;
  localparam logic [63:0] BILLION      = 64'd1000000000;
  localparam logic [63:0] NS_TOP       = 64'd999999999;
  localparam logic [29:0] NS_ALL_ONES  = 30'h3FFF_FFFF;

  // Cycles without any handshake before the run is declared hung
  localparam int HANG_LIMIT     = 4000;
  // Cycles to keep running after the last expected result has arrived
  localparam int DRAIN_CYCLES   = 40;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct packed {
    logic [63:0] sec;
    logic [29:0] ns;
    logic        err;
  } time_result_t;

  // One row of the directed table; typed = 1 means the expected result is given
  typedef struct packed {
    logic [63:0] sec;
    logic [29:0] ns;
    logic [31:0] fac;
    logic        typed;
    logic [63:0] exp_sec;
    logic [29:0] exp_ns;
    logic        exp_err;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [63:0] seconds_in, [93:64] nanos_in, [125:94] scale_factor, [127:126] zero
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [63:0] seconds_out, [93:64] nanos_out, [95:94] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // [0] range_error
  logic [M_TUSER_W-1:0] m_axis_tuser;

  time_result_t expected_products[$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  time_value_scale_saturating #(
    .SECONDS_WIDTH(64),
    .FACTOR_WIDTH (32)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Floor product of seconds.nanos times a signed factor, saturated on overflow.
  function automatic time_result_t scale_time_value(input logic [63:0] sec_raw,
                                                    input logic [29:0] ns_raw,
                                                    input logic [31:0] fac_raw);
    time_result_t res;
    logic         neg_prod;
    logic         sat;
    logic [31:0]  fac_neg;
    logic [63:0]  fmag;
    logic [63:0]  smag;
    logic [63:0]  nsv;
    logic [63:0]  carry;
    logic [63:0]  rsec;
    neg_prod = sec_raw[63] ^ fac_raw[31];
    sat      = 1'b0;
    smag     = '0;
    nsv      = {34'd0, ns_raw};
    fac_neg  = 32'd0 - fac_raw;
    fmag     = fac_raw[31] ? {32'd0, fac_neg} : {32'd0, fac_raw};
    if (fac_raw == 32'd0) begin
      res = '{sec: '0, ns: '0, err: 1'b0};
    end else if (fac_raw == 32'd1) begin
      // pass through untouched, even an out-of-range nanosecond part
      res = '{sec: sec_raw, ns: ns_raw, err: 1'b0};
    end else begin
      if (nsv > NS_TOP) nsv = NS_TOP;
      // form the magnitude; the most negative seconds has none and saturates
      if (sec_raw[63]) begin
        if (sec_raw == SEC_MIN) begin
          sat = 1'b1;
        end else begin
          smag = 64'd0 - sec_raw;
          if (nsv != 0) begin
            smag = smag - 64'd1;
            nsv  = BILLION - nsv;
          end
        end
      end else begin
        smag = sec_raw;
      end
      if (!sat) begin
        nsv   = nsv * fmag;
        carry = nsv / BILLION;
        nsv   = nsv % BILLION;
        if (smag > SEC_MAX / fmag) begin
          sat = 1'b1;
        end else begin
          smag = smag * fmag;
          if (carry > SEC_MAX || smag > SEC_MAX - carry) sat = 1'b1;
          else smag = smag + carry;
        end
      end
      if (sat) begin
        if (neg_prod) res = '{sec: SEC_MIN, ns: '0, err: 1'b1};
        else res = '{sec: SEC_MAX, ns: NS_TOP[29:0], err: 1'b1};
      end else if (neg_prod) begin
        // restore the sign, borrowing a second for a nonzero remainder
        rsec = 64'd0 - smag;
        if (nsv != 0) begin
          rsec = rsec - 64'd1;
          nsv  = BILLION - nsv;
        end
        res = '{sec: rsec, ns: nsv[29:0], err: 1'b0};
      end else begin
        res = '{sec: smag, ns: nsv[29:0], err: 1'b0};
      end
    end
    return res;
  endfunction

  // Present one request and hold it until the block takes it. Idle cycles go
  // in front; tvalid stays high between back-to-back requests.
  task automatic send_request(input logic [63:0] sec, input logic [29:0] ns,
                              input logic [31:0] fac);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, fac, ns, sec};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Draw one random request, weighted toward the saturation boundary and the
  // special factors, with some out-of-range nanoseconds mixed in.
  task automatic draw_request(output logic [63:0] sec, output logic [29:0] ns,
                              output logic [31:0] fac);
    logic [31:0] mag32;
    logic [31:0] fac_neg;
    logic [63:0] fmag;
    logic [63:0] edge_sec;
    case ($urandom_range(9))
      0:       fac = 32'd0;
      1:       fac = 32'd1;
      2:       fac = 32'hFFFF_FFFF;
      3, 4:    fac = 32'($urandom_range(32)) - 32'd16;
      5:       fac = $urandom;
      6: begin
        case ($urandom_range(3))
          0:       fac = FAC_MIN;
          1:       fac = FAC_MAX;
          2:       fac = FAC_MIN + 32'd1;
          default: fac = 32'd2;
        endcase
      end
      default: begin
        mag32 = $urandom >> $urandom_range(31);
        fac   = $urandom_range(1) ? 32'd0 - mag32 : mag32;
      end
    endcase
    fac_neg = 32'd0 - fac;
    fmag    = fac[31] ? {32'd0, fac_neg} : {32'd0, fac};
    if (fmag == 0) fmag = 64'd1;
    case ($urandom_range(7))
      0, 1:    sec = 64'($urandom_range(2000)) - 64'd1000;
      2:       sec = {$urandom, $urandom};
      3: begin
        case ($urandom_range(4))
          0:       sec = SEC_MIN;
          1:       sec = SEC_MAX;
          2:       sec = SEC_MIN + 64'd1;
          3:       sec = '1;
          default: sec = '0;
        endcase
      end
      4, 5: begin
        // land right around the largest magnitude that still fits
        edge_sec = SEC_MAX / fmag + 64'($urandom_range(4)) - 64'd2;
        sec      = $urandom_range(1) ? 64'd0 - edge_sec : edge_sec;
      end
      default: begin
        edge_sec = {$urandom, $urandom} >> $urandom_range(63);
        sec      = $urandom_range(1) ? 64'd0 - edge_sec : edge_sec;
      end
    endcase
    case ($urandom_range(9))
      0:       ns = '0;
      1:       ns = NS_TOP[29:0];
      2:       ns = 30'(BILLION) + 30'($urandom_range(NS_ALL_ONES - 30'(BILLION)));
      3:       ns = 30'($urandom_range(1000));
      default: ns = 30'($urandom_range(999999999));
    endcase
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    time_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_products.size() == 0) begin
        $error("result with no request pending: seconds_out %0d", $signed(m_axis_tdata[63:0]));
        fail_count++;
      end else begin
        want = expected_products.pop_front();
        if (m_axis_tdata[63:0] !== want.sec) begin
          $error("seconds_out: expected %0d, got %0d", $signed(want.sec),
                 $signed(m_axis_tdata[63:0]));
          fail_count++;
        end
        if (m_axis_tdata[93:64] !== want.ns) begin
          $error("nanos_out: expected %0d, got %0d", want.ns, m_axis_tdata[93:64]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.err) begin
          $error("range_error: expected %0b, got %0b", want.err, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run once no handshake has happened for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    wait (!rst);
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("time_value_scale_saturating: mismatch");
    $finish;
  end

  initial begin
    stim_row_t    directed_rows [DIRECTED_ROWS];
    logic [63:0]  sec;
    logic [29:0]  ns;
    logic [31:0]  fac;
    int           idle_plan [4];
    int           stall_plan [4];

    // Directed table: sec, ns, fac, typed, expected sec, ns, flag
    directed_rows = '{
      // factor zero clears everything
      '{64'd12345, 30'd678, 32'd0, 1'b1, 64'd0, 30'd0, 1'b0},
      // factor one passes through, negative seconds included
      '{-64'sd5, 30'd123, 32'd1, 1'b1, -64'sd5, 30'd123, 1'b0},
      // factor one keeps an out-of-range nanosecond part as is
      '{64'd7, NS_ALL_ONES, 32'd1, 1'b1, 64'd7, NS_ALL_ONES, 1'b0},
      '{SEC_MIN, 30'd0, 32'd1, 1'b1, SEC_MIN, 30'd0, 1'b0},
      '{SEC_MIN, 30'd5, 32'd0, 1'b1, 64'd0, 30'd0, 1'b0},
      // most negative seconds saturates for any factor other than zero or one
      '{SEC_MIN, 30'd0, 32'd2, 1'b1, SEC_MIN, 30'd0, 1'b1},
      '{SEC_MIN, 30'd17, 32'hFFFF_FFFF, 1'b1, SEC_MAX, NS_TOP[29:0], 1'b1},
      // plain overflow both ways
      '{SEC_MAX, 30'd0, 32'd2, 1'b1, SEC_MAX, NS_TOP[29:0], 1'b1},
      '{SEC_MAX, 30'd0, -32'sd2, 1'b1, SEC_MIN, 30'd0, 1'b1},
      // carry of whole seconds out of the nanoseconds
      '{64'd3, 30'd500000000, 32'd2, 1'b1, 64'd7, 30'd0, 1'b0},
      // negative input magnitude with nonzero nanoseconds
      '{-64'sd1, 30'd500000000, 32'd2, 1'b1, -64'sd1, 30'd0, 1'b0},
      '{-64'sd2, 30'd250000000, -32'sd4, 1'b1, 64'd7, 30'd0, 1'b0},
      // out-of-range nanoseconds get clamped first
      '{64'd0, NS_ALL_ONES, 32'd2, 1'b1, 64'd1, 30'd999999998, 1'b0},
      // negative products, borrowing a second for a nonzero remainder
      '{64'd5, 30'd1, 32'hFFFF_FFFF, 1'b1, -64'sd6, 30'd999999999, 1'b0},
      '{64'd1, 30'd0, FAC_MIN, 1'b1, -64'sd2147483648, 30'd0, 1'b0},
      '{-64'sd1, 30'd0, FAC_MAX, 1'b0, '0, '0, 1'b0},
      '{SEC_MAX, 30'd0, FAC_MAX, 1'b1, SEC_MAX, NS_TOP[29:0], 1'b1},
      // the carry lands exactly on the largest seconds
      '{64'h3FFF_FFFF_FFFF_FFFF, 30'd999999999, 32'd2, 1'b1, SEC_MAX, 30'd999999998, 1'b0},
      '{64'hC000_0000_0000_0000, 30'd0, 32'd2, 1'b0, '0, '0, 1'b0},
      '{-64'sd1, 30'd999999999, 32'd3, 1'b0, '0, '0, 1'b0},
      '{64'd0, 30'd0, -32'sd7, 1'b1, 64'd0, 30'd0, 1'b0},
      '{SEC_MIN + 64'd1, 30'd1, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, NS_ALL_ONES, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0},
      '{64'd86400, 30'd123456789, 32'd1000, 1'b0, '0, '0, 1'b0},
      '{SEC_MAX, 30'd999999999, 32'd1, 1'b1, SEC_MAX, 30'd999999999, 1'b0}
    };
    // phases: no idling, sender idle, receiver stalling, both
    idle_plan  = '{0, 70, 0, 18};
    stall_plan = '{0, 0, 70, 18};

    // Hold reset at the start, then release it once for the whole run.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with no idling on either side.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].sec, directed_rows[i].ns, directed_rows[i].fac);
      if (directed_rows[i].typed)
        expected_products.push_back('{sec: directed_rows[i].sec == directed_rows[i].sec ?
                                     directed_rows[i].exp_sec : '0,
                                     ns: directed_rows[i].exp_ns,
                                     err: directed_rows[i].exp_err});
      else
        expected_products.push_back(scale_time_value(directed_rows[i].sec,
                                                     directed_rows[i].ns,
                                                     directed_rows[i].fac));
    end

    // Random requests, one batch per idling phase; no state, so no need to drain
    // between phases.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        draw_request(sec, ns, fac);
        send_request(sec, ns, fac);
        expected_products.push_back(scale_time_value(sec, ns, fac));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every result, then idle for DRAIN_CYCLES before reporting.
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("time_value_scale_saturating: match");
    else
      $display("time_value_scale_saturating: mismatch");
    $finish;
  end

endmodule

>>> time_value_scale_saturating.f
+incdir+rtl
rtl/tvss_pkg.sv
rtl/time_value_scale_saturating.sv
rtl/tvss_checker.sv
tb/sv/tb_time_value_scale_saturating.sv
